@@ rtl/core/lpmd_pkg.sv @@
package lpmd_pkg;

  localparam int TOPIC_CHARS_DEF = 50;
  localparam int QUEUE_DEPTH     = 8;

  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_SKIP    = 2'd1,
    PH_HEADER  = 2'd2,
    PH_CONTENT = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TOPIC   = 2'd0,
    KIND_STRING  = 2'd1,
    KIND_SUMMARY = 2'd2,
    KIND_SKIP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_UNKNOWN = 2'd2
  } status_t;

  localparam logic [7:0] TYPE_INT        = 8'd0;
  localparam logic [7:0] TYPE_SHORT_REAL = 8'd1;
  localparam logic [7:0] TYPE_FLOAT      = 8'd2;
  localparam logic [7:0] TYPE_STRING     = 8'd3;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  vtype;
    logic        neg;
    logic [31:0] mag;
    logic [7:0]  dec;
    status_t     status;
    logic        last;
  } rec_t;

  // up to two records per accepted byte, rec0 always first
  typedef struct packed {
    logic v0;
    logic v1;
    rec_t rec0;
    rec_t rec1;
  } push_t;

endpackage

@@ rtl/core/lpmd_in_if.sv @@
interface lpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

@@ rtl/core/lpmd_out_if.sv @@
interface lpmd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  data_byte;
  logic [31:0] source_address;
  logic [15:0] source_port;
  logic [7:0]  value_type;
  logic        negative;
  logic [31:0] magnitude;
  logic [7:0]  decimals;
  logic [1:0]  value_status;
  logic        last;

  modport source (
    output valid, output record_kind, output data_byte, output source_address,
    output source_port, output value_type, output negative, output magnitude,
    output decimals, output value_status, output last, input ready
  );
  modport sink (
    input valid, input record_kind, input data_byte, input source_address,
    input source_port, input value_type, input negative, input magnitude,
    input decimals, input value_status, input last, output ready
  );
endinterface

@@ rtl/core/lpmd_parser.sv @@
module lpmd_parser
  import lpmd_pkg::*;
#(
  parameter int TOPIC_CHARS = TOPIC_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] in_byte,
  output push_t      push
);

  localparam int HEADER_BYTES = TOPIC_CHARS + 8;
  localparam int HW           = $clog2(HEADER_BYTES);
  localparam logic [HW-1:0] IDX_LEN_LAST  = HW'(3);
  localparam logic [HW-1:0] IDX_ADDR_END  = HW'(4);
  localparam logic [HW-1:0] IDX_PORT_END  = HW'(6);
  localparam logic [HW-1:0] IDX_TOPIC_END = HW'(TOPIC_CHARS + 6);
  localparam logic [HW-1:0] IDX_TYPE      = HW'(HEADER_BYTES - 1);
  localparam logic [31:0]   HDR_LEN       = 32'(HEADER_BYTES);

  phase_t      phase, phase_next;
  logic [31:0] frame_length, frame_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [HW-1:0] header_index, header_index_next;
  logic [31:0] sender_address, sender_address_next;
  logic [15:0] sender_port, sender_port_next;
  logic [7:0]  type_code, type_code_next;
  logic        topic_ended, topic_ended_next;
  logic [2:0]  content_index, content_index_next;
  logic [7:0]  sign_byte, sign_byte_next;
  logic [31:0] value_accum, value_accum_next;
  logic [7:0]  power_byte, power_byte_next;
  logic [31:0] len_full;
  logic [31:0] left_dec;
  push_t       push_next;

  function automatic rec_t make_summary(
    input logic [31:0] addr,
    input logic [15:0] port,
    input logic [7:0]  tcode,
    input logic [2:0]  cidx,
    input logic [7:0]  sgn,
    input logic [31:0] acc,
    input logic [7:0]  pwr
  );
    rec_t r;
    logic [2:0] need;
    r        = '0;
    r.kind   = KIND_SUMMARY;
    r.last   = 1'b1;
    r.addr   = addr;
    r.port   = port;
    r.vtype  = tcode;
    r.status = STATUS_OK;
    need     = (tcode == TYPE_INT) ? 3'd5 : 3'd6;
    if (tcode == TYPE_INT || tcode == TYPE_FLOAT) begin
      if (cidx < need) begin
        r.status = STATUS_SHORT;
      end else begin
        r.neg = (sgn == 8'd1) && (acc != 32'd0);
        r.mag = acc;
        r.dec = (tcode == TYPE_FLOAT) ? pwr : 8'd0;
      end
    end else if (tcode == TYPE_SHORT_REAL) begin
      if (cidx < 3'd2) begin
        r.status = STATUS_SHORT;
      end else begin
        r.mag = {16'd0, acc[15:0]};
        r.dec = 8'd2;
      end
    end else if (tcode != TYPE_STRING) begin
      r.status = STATUS_UNKNOWN;
    end
    return r;
  endfunction

  function automatic rec_t make_plain(input kind_t k, input logic [7:0] d, input logic l);
    rec_t r;
    r        = '0;
    r.kind   = k;
    r.data   = d;
    r.status = STATUS_OK;
    r.last   = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN;
      frame_length   <= '0;
      bytes_left     <= '0;
      header_index   <= '0;
      sender_address <= '0;
      sender_port    <= '0;
      type_code      <= '0;
      topic_ended    <= 1'b0;
      content_index  <= '0;
      sign_byte      <= '0;
      value_accum    <= '0;
      power_byte     <= '0;
      push           <= '0;
    end else begin
      phase          <= phase_next;
      frame_length   <= frame_length_next;
      bytes_left     <= bytes_left_next;
      header_index   <= header_index_next;
      sender_address <= sender_address_next;
      sender_port    <= sender_port_next;
      type_code      <= type_code_next;
      topic_ended    <= topic_ended_next;
      content_index  <= content_index_next;
      sign_byte      <= sign_byte_next;
      value_accum    <= value_accum_next;
      power_byte     <= power_byte_next;
      push           <= push_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    frame_length_next   = frame_length;
    bytes_left_next     = bytes_left;
    header_index_next   = header_index;
    sender_address_next = sender_address;
    sender_port_next    = sender_port;
    type_code_next      = type_code;
    topic_ended_next    = topic_ended;
    content_index_next  = content_index;
    sign_byte_next      = sign_byte;
    value_accum_next    = value_accum;
    power_byte_next     = power_byte;
    push_next           = '0;
    len_full            = {frame_length[23:0], in_byte};
    left_dec            = bytes_left - 32'd1;

    if (fire) begin
      case (phase)
        PH_LEN: begin
          frame_length_next = len_full;
          header_index_next = header_index + HW'(1);
          if (header_index == IDX_LEN_LAST) begin
            header_index_next = '0;
            frame_length_next = '0;
            if (len_full < HDR_LEN) begin
              if (len_full == 32'd0) begin
                push_next.v0   = 1'b1;
                push_next.rec0 = make_plain(KIND_SKIP, 8'd0, 1'b1);
              end else begin
                bytes_left_next = len_full;
                phase_next      = PH_SKIP;
              end
            end else begin
              bytes_left_next     = len_full - HDR_LEN;
              sender_address_next = '0;
              sender_port_next    = '0;
              type_code_next      = '0;
              topic_ended_next    = 1'b0;
              content_index_next  = '0;
              sign_byte_next      = '0;
              value_accum_next    = '0;
              power_byte_next     = '0;
              phase_next          = PH_HEADER;
            end
          end
        end
        PH_SKIP: begin
          bytes_left_next = left_dec;
          if (left_dec == 32'd0) begin
            push_next.v0   = 1'b1;
            push_next.rec0 = make_plain(KIND_SKIP, 8'd0, 1'b1);
            phase_next     = PH_LEN;
          end
        end
        PH_HEADER: begin
          if (header_index < IDX_ADDR_END) begin
            sender_address_next = {sender_address[23:0], in_byte};
          end else if (header_index < IDX_PORT_END) begin
            sender_port_next = {sender_port[7:0], in_byte};
          end else if (header_index == IDX_TYPE) begin
            type_code_next = in_byte;
          end else if (header_index < IDX_TOPIC_END && !topic_ended) begin
            // the byte after the last topic character is the terminator slot
            if (in_byte == 8'd0) begin
              topic_ended_next = 1'b1;
            end else begin
              push_next.v0   = 1'b1;
              push_next.rec0 = make_plain(KIND_TOPIC, in_byte, 1'b0);
            end
          end
          header_index_next = header_index + HW'(1);
          if (header_index == IDX_TYPE) begin
            header_index_next = '0;
            if (bytes_left == 32'd0) begin
              push_next.v0   = 1'b1;
              push_next.rec0 = make_summary(sender_address, sender_port, in_byte, 3'd0,
                                            sign_byte, value_accum, power_byte);
              phase_next     = PH_LEN;
            end else begin
              phase_next = PH_CONTENT;
            end
          end
        end
        default: begin
          if (type_code == TYPE_STRING) begin
            push_next.v0   = 1'b1;
            push_next.rec0 = make_plain(KIND_STRING, in_byte, 1'b0);
          end else if (type_code == TYPE_INT || type_code == TYPE_FLOAT) begin
            if (content_index == 3'd0) begin
              sign_byte_next = in_byte;
            end else if (content_index <= 3'd4) begin
              value_accum_next = {value_accum[23:0], in_byte};
            end else if (content_index == 3'd5 && type_code == TYPE_FLOAT) begin
              power_byte_next = in_byte;
            end
          end else if (type_code == TYPE_SHORT_REAL) begin
            if (content_index < 3'd2) begin
              value_accum_next = {16'd0, value_accum[7:0], in_byte};
            end
          end
          if (content_index < 3'd6) begin
            content_index_next = content_index + 3'd1;
          end
          bytes_left_next = left_dec;
          if (left_dec == 32'd0) begin
            phase_next = PH_LEN;
            if (push_next.v0) begin
              push_next.v1   = 1'b1;
              push_next.rec1 = make_summary(sender_address, sender_port, type_code,
                                            content_index_next, sign_byte_next,
                                            value_accum_next, power_byte_next);
            end else begin
              push_next.v0   = 1'b1;
              push_next.rec0 = make_summary(sender_address, sender_port, type_code,
                                            content_index_next, sign_byte_next,
                                            value_accum_next, power_byte_next);
            end
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/core/lpmd_queue.sv @@
module lpmd_queue
  import lpmd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  space,
  lpmd_out_if.source records
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rec_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] count, count_next;
  logic [1:0]    n_push;
  logic          pop;
  rec_t          head;

  assign n_push = {1'b0, push.v0} + {1'b0, push.v1};
  assign pop    = (count != '0) && records.ready;
  // two free entries on top of whatever is in flight from the parser
  assign space  = (count + CW'(n_push)) <= CW'(QUEUE_DEPTH - 2);

  always_comb begin
    count_next = count + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wp    <= '0;
      rp    <= '0;
    end else begin
      count <= count_next;
      wp    <= wp + PW'(n_push);
      if (pop) begin
        rp <= rp + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wp] <= push.rec0;
    end
    if (push.v1) begin
      mem[wp + PW'(1)] <= push.rec1;
    end
  end

  assign head                   = mem[rp];
  assign records.valid          = (count != '0);
  assign records.record_kind    = head.kind;
  assign records.data_byte      = head.data;
  assign records.source_address = head.addr;
  assign records.source_port    = head.port;
  assign records.value_type     = head.vtype;
  assign records.negative       = head.neg;
  assign records.magnitude      = head.mag;
  assign records.decimals       = head.dec;
  assign records.value_status   = head.status;
  assign records.last           = head.last;

endmodule

@@ rtl/core/length_prefixed_message_deframer_core.sv @@
// a result is registered by the parser, then written into the output queue before it is offered
// throughput: one byte per cycle absent output backpressure; a byte yields at most two
// records (string byte plus summary); the parser registers its records into a small
// output queue; input stalls only in reset or when the queue cannot take two more records
// reset: synchronous, active high; parser returns to reading the length, queue empties
module length_prefixed_message_deframer_core
  import lpmd_pkg::*;
#(
  parameter int TOPIC_CHARS = TOPIC_CHARS_DEF
) (
  input  logic clk,
  input  logic rst,
  lpmd_in_if.sink    stream,
  lpmd_out_if.source records
);

  push_t push;
  logic  space;
  logic  fire;

  assign stream.ready = space && !rst;
  assign fire         = stream.valid && stream.ready;

  lpmd_parser #(
    .TOPIC_CHARS(TOPIC_CHARS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (stream.stream_byte),
    .push    (push)
  );

  lpmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .space   (space),
    .records (records)
  );

endmodule
